// ===== rtl/peer_table_with_aging_core_macros.svh =====
// Assertion macros for the peer table core.
`ifndef PEER_TABLE_WITH_AGING_CORE_MACROS_SVH
`define PEER_TABLE_WITH_AGING_CORE_MACROS_SVH

// Same-cycle implication, gated by reset.
`define PTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated by reset.
`define PTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pta_pkg.sv =====
// Shared constants and types for the peer table core.
package pta_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int TIME_W    = 32;
	localparam int TIMEOUT_W = 16;
	localparam int OUTCOME_W = 2;
	localparam int SLOT_W    = 4;
	localparam int COUNT_W   = 5;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

	localparam logic [OUTCOME_W-1:0] OUTCOME_ADDED     = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_REFRESHED = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED   = 2'd2;

	// phase strobes broadcast to every cell
	typedef struct packed {
		logic match_en;
		logic write_en;
		logic sweep_en;
	} cell_ctrl_t;

endpackage

// ===== rtl/pta_if.sv =====
// Word channel interfaces: keep-alive words in, result words out.
interface pta_in_if;
	import pta_pkg::*;

	logic              valid;
	logic              ready;
	logic [IP_W-1:0]   ip_address;
	logic [MAC_W-1:0]  mac_address;
	logic [TIME_W-1:0] now_seconds;

	modport source (output valid, output ip_address, output mac_address,
		output now_seconds, input ready);
	modport sink (input valid, input ip_address, input mac_address,
		input now_seconds, output ready);
endinterface

interface pta_out_if;
	import pta_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OUTCOME_W-1:0] outcome;
	logic [SLOT_W-1:0]    slot_index;
	logic [COUNT_W-1:0]   live_count;
	logic [COUNT_W-1:0]   expired_count;

	modport source (output valid, output outcome, output slot_index,
		output live_count, output expired_count, input ready);
	modport sink (input valid, input outcome, input slot_index,
		input live_count, input expired_count, output ready);
endinterface

// ===== rtl/peer_table_with_aging_core.sv =====
// Peer table core: keep-alive lookup, insert and aging over a row of slot cells.
// A word accepted while idle runs through the four-step sequencer over the cell row (match,
// claim/write, expiry sweep, count); the count step loads its result into the output register.
// No new word is taken until the sequencer is back in idle.
// A waiting result does not block the next word; only a full output register holds the count step.
// Reset: asynchronous, active low; table empty, timeout 30 s, no clearing pass needed.
module peer_table_with_aging_core (
	input  logic                           clk,
	input  logic                           arst_n,
	pta_in_if.sink                         keepalive,
	pta_out_if.source                      report,
	input  logic                           cfg_we,
	input  logic [pta_pkg::TIMEOUT_W-1:0]  cfg_wdata
);
	import pta_pkg::*;

	`include "peer_table_with_aging_core_macros.svh"

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MATCH = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_COUNT = 3'd4;

	logic [2:0]           state_q;
	logic [2:0]           state_d;
	logic [TIMEOUT_W-1:0] timeout_q;

	// captured keep-alive
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;
	logic [TIME_W-1:0] now_q;

	// decision from the claim step
	logic [OUTCOME_W-1:0] outcome_q;
	logic [IDX_W-1:0]     slot_q;

	// output register
	logic                 out_valid_q;
	logic [OUTCOME_W-1:0] out_outcome_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic [COUNT_W-1:0]   out_live_q;
	logic [COUNT_W-1:0]   out_expired_q;

	cell_ctrl_t ctrl;

	// cell row signals; claim and index ripple from slot 0 upward
	logic [TABLE_ENTRIES:0]   claim;
	logic [IDX_W-1:0]         idx_chain [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] valid_vec;
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] expired_vec;
	logic                     hit_any;

	logic accept;
	logic out_free;
	logic [CNT_W-1:0] live_cnt;
	logic [CNT_W-1:0] exp_cnt;

	assign accept          = keepalive.valid && keepalive.ready;
	assign keepalive.ready = (state_q == S_IDLE);
	assign out_free        = !out_valid_q || report.ready;

	assign ctrl.match_en = (state_q == S_MATCH);
	assign ctrl.write_en = (state_q == S_WRITE);
	assign ctrl.sweep_en = (state_q == S_SWEEP);

	assign hit_any      = |hit_vec;
	assign claim[0]     = 1'b0;
	assign idx_chain[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		pta_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.my_index  (IDX_W'(i)),
			.key_ip    (ip_q),
			.key_mac   (mac_q),
			.now       (now_q),
			.timeout   (timeout_q),
			.hit_any   (hit_any),
			.claim_in  (claim[i]),
			.claim_out (claim[i+1]),
			.idx_in    (idx_chain[i]),
			.idx_out   (idx_chain[i+1]),
			.valid     (valid_vec[i]),
			.hit       (hit_vec[i]),
			.expired   (expired_vec[i])
		);
	end

	// counts after the sweep has settled the valid bits
	assign live_cnt = CNT_W'($countones(valid_vec));
	assign exp_cnt  = CNT_W'($countones(expired_vec));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) begin
				state_d = S_MATCH;
			end
			S_MATCH: state_d = S_WRITE;
			S_WRITE: state_d = S_SWEEP;
			S_SWEEP: state_d = S_COUNT;
			S_COUNT: if (out_free) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (state_q == S_COUNT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ip_q  <= keepalive.ip_address;
			mac_q <= keepalive.mac_address;
			now_q <= keepalive.now_seconds;
		end
		// refresh beats insert; no claim at all means the table is full
		if (state_q == S_WRITE) begin
			slot_q <= idx_chain[TABLE_ENTRIES];
			if (hit_any) begin
				outcome_q <= OUTCOME_REFRESHED;
			end else if (claim[TABLE_ENTRIES]) begin
				outcome_q <= OUTCOME_ADDED;
			end else begin
				outcome_q <= OUTCOME_DROPPED;
			end
		end
		if (state_q == S_COUNT && out_free) begin
			out_outcome_q <= outcome_q;
			out_slot_q    <= SLOT_W'(slot_q);
			out_live_q    <= COUNT_W'(live_cnt);
			out_expired_q <= COUNT_W'(exp_cnt);
		end
	end

	assign report.valid         = out_valid_q;
	assign report.outcome       = out_outcome_q;
	assign report.slot_index    = out_slot_q;
	assign report.live_count    = out_live_q;
	assign report.expired_count = out_expired_q;

	// an address never sits in two live slots
	`PTA_ASSERT_NOW(a_single_match, clk, arst_n, state_q == S_WRITE, $onehot0(hit_vec), "address matched in more than one slot")
	// a drop only happens with every slot live
	`PTA_ASSERT_NOW(a_drop_when_full, clk, arst_n, state_q == S_WRITE && !hit_any && !claim[TABLE_ENTRIES], &valid_vec, "drop with a free slot")
	// a finished count always lands in the output register
	`PTA_ASSERT_NEXT(a_count_lands, clk, arst_n, state_q == S_COUNT && out_free, out_valid_q && state_q == S_IDLE, "result not registered")

endmodule

// ===== rtl/pta_cell.sv =====
// One table slot: stores a peer, matches the key IP, claims, ages out.
module pta_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pta_pkg::cell_ctrl_t          ctrl,
	input  logic [pta_pkg::IDX_W-1:0]    my_index,
	input  logic [pta_pkg::IP_W-1:0]     key_ip,
	input  logic [pta_pkg::MAC_W-1:0]    key_mac,
	input  logic [pta_pkg::TIME_W-1:0]   now,
	input  logic [pta_pkg::TIMEOUT_W-1:0] timeout,
	input  logic                         hit_any,
	input  logic                         claim_in,
	output logic                         claim_out,
	input  logic [pta_pkg::IDX_W-1:0]    idx_in,
	output logic [pta_pkg::IDX_W-1:0]    idx_out,
	output logic                         valid,
	output logic                         hit,
	output logic                         expired
);
	import pta_pkg::*;

	logic              valid_q;
	logic              hit_q;
	logic              expired_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;
	logic [TIME_W-1:0] seen_q;
	logic              sel;
	logic [TIME_W-1:0] age;
	logic              too_old;

	// lowest matching slot wins on refresh, lowest free slot on insert
	assign sel       = !claim_in && (hit_any ? hit_q : !valid_q);
	assign claim_out = claim_in | sel;
	assign idx_out   = idx_in | (sel ? my_index : '0);

	assign age     = now - seen_q;
	assign too_old = valid_q && (age > TIME_W'(timeout));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			hit_q     <= 1'b0;
			expired_q <= 1'b0;
		end else begin
			if (ctrl.match_en) begin
				hit_q <= valid_q && (ip_q == key_ip);
			end
			if (ctrl.write_en && sel && !hit_any) begin
				valid_q <= 1'b1;
			end
			if (ctrl.sweep_en) begin
				expired_q <= too_old;
				if (too_old) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.write_en && sel) begin
			seen_q <= now;
			if (!hit_any) begin
				ip_q  <= key_ip;
				mac_q <= key_mac;
			end
		end
	end

	assign valid   = valid_q;
	assign hit     = hit_q;
	// stored MAC has no read path in this core; kept for table contents
	assign expired = expired_q & (|{mac_q, 1'b1});

endmodule

// ===== verif/peer_table_with_aging_core_tb.sv =====
// Testbench for the peer table core: directed and random keep-alives checked against a predictor.
module peer_table_with_aging_core_tb;
	import pta_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int GAP_PCT      = 27;   // chance of an idle cycle on either side
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the block
	localparam int DRAIN_CYCLES = 8;    // latency margin before a timeout write
	localparam int STALL_LIMIT  = 3000; // cycles with no word moving on either side
	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 300;

	// One expected or observed result word.
	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [SLOT_W-1:0]    slot;
		logic [COUNT_W-1:0]   live;
		logic [COUNT_W-1:0]   expired;
	} report_t;

	// Predicts the table contents word by word and holds the results not yet seen.
	class peer_scoreboard;
		bit                   occupied[TABLE_ENTRIES];
		logic [IP_W-1:0]      peer_ip[TABLE_ENTRIES];
		logic [MAC_W-1:0]     peer_mac[TABLE_ENTRIES];
		logic [TIME_W-1:0]    last_seen[TABLE_ENTRIES];
		int unsigned          live_total;
		logic [TIMEOUT_W-1:0] timeout;
		report_t              awaiting[$];
		int                   errors;

		function new();
			foreach (occupied[i])
				occupied[i] = 1'b0;
			live_total = 0;
			timeout = TIMEOUT_RESET;
			errors = 0;
		endfunction

		function void set_timeout(input logic [TIMEOUT_W-1:0] value);
			timeout = value;
		endfunction

		function int pending();
			return awaiting.size();
		endfunction

		// Lookup, insert or refresh, then the aging sweep.
		function void note_keepalive(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
				input logic [TIME_W-1:0] now);
			int hit;
			int free_slot;
			int unsigned gone;
			logic [TIME_W-1:0] age;
			report_t r;
			hit = -1;
			free_slot = -1;
			gone = 0;
			r = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (hit < 0 && occupied[i] && peer_ip[i] == ip)
					hit = i;
				if (free_slot < 0 && !occupied[i])
					free_slot = i;
			end
			if (hit >= 0) begin
				last_seen[hit] = now;
				r.outcome = OUTCOME_REFRESHED;
				r.slot = hit[SLOT_W-1:0];
			end else if (free_slot >= 0) begin
				occupied[free_slot] = 1'b1;
				peer_ip[free_slot] = ip;
				peer_mac[free_slot] = mac;
				last_seen[free_slot] = now;
				live_total++;
				r.outcome = OUTCOME_ADDED;
				r.slot = free_slot[SLOT_W-1:0];
			end else begin
				r.outcome = OUTCOME_DROPPED;
			end
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (occupied[i]) begin
					age = now - last_seen[i];
					if (age > TIME_W'(timeout)) begin
						occupied[i] = 1'b0;
						live_total--;
						gone++;
					end
				end
			end
			r.live = live_total[COUNT_W-1:0];
			r.expired = gone[COUNT_W-1:0];
			awaiting.push_back(r);
		endfunction

		function void compare_field(input string field, input int unsigned want,
				input int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_report(input report_t got);
			report_t want;
			if (awaiting.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = awaiting.pop_front();
			compare_field("outcome", want.outcome, got.outcome);
			compare_field("slot_index", want.slot, got.slot);
			compare_field("live_count", want.live, got.live);
			compare_field("expired_count", want.expired, got.expired);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;

	pta_in_if  ka_bus();
	pta_out_if rpt_bus();

	peer_table_with_aging_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.keepalive (ka_bus),
		.report    (rpt_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	peer_scoreboard sb;
	bit             gaps_on;    // random idling on both sides
	bit             hold_req;   // asks the receiver for one long hold-off
	int             stall_count;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Receiver: random ready, plus one long hold-off counted here so that the
	// sender keeps offering words while the output side is blocked.
	initial begin
		rpt_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rpt_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rpt_bus.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PCT);
		end
	end

	// Monitor: values read right after the edge are the ones the edge sampled.
	// Input words feed the predictor, result words are checked in order, and a
	// watchdog ends the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (ka_bus.valid && ka_bus.ready)
				sb.note_keepalive(ka_bus.ip_address, ka_bus.mac_address, ka_bus.now_seconds);
			if (rpt_bus.valid && rpt_bus.ready)
				sb.check_report({rpt_bus.outcome, rpt_bus.slot_index, rpt_bus.live_count,
					rpt_bus.expired_count});
			if ((ka_bus.valid && ka_bus.ready) || (rpt_bus.valid && rpt_bus.ready))
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("%0t: watchdog, no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offer one keep-alive word and hold it until the block takes it. Valid is
	// left high so back-to-back words need no second assignment in one step.
	task automatic offer_keepalive(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
			input logic [TIME_W-1:0] now);
		while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
			ka_bus.valid <= 1'b0;
			@(posedge clk);
		end
		ka_bus.valid       <= 1'b1;
		ka_bus.ip_address  <= ip;
		ka_bus.mac_address <= mac;
		ka_bus.now_seconds <= now;
		do @(posedge clk); while (!ka_bus.ready);
	endtask

	// Timeout writes only with the block idle: every result back, then latency margin.
	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		ka_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_timeout(value);
	endtask

	function automatic logic [MAC_W-1:0] random_mac();
		return MAC_W'({$urandom, $urandom});
	endfunction

	initial begin
		logic [TIMEOUT_W-1:0] phase_timeout[PHASES];
		logic [IP_W-1:0]      peer_pool[32];
		logic [TIME_W-1:0]    clock_s;
		logic [IP_W-1:0]      ip;
		int                   pool_n;
		int                   step_max;
		int                   pick;

		sb = new();
		stall_count = 0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		ka_bus.valid = 1'b0;
		ka_bus.ip_address = '0;
		ka_bus.mac_address = '0;
		ka_bus.now_seconds = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset timeout of 30 s.
		// Field extremes on an empty table, then a refresh that keeps the stored MAC.
		offer_keepalive('0, '0, 32'd0);
		offer_keepalive('1, '1, 32'd5);
		offer_keepalive('0, random_mac(), 32'd10);
		// Fill the remaining fourteen slots.
		for (int i = 2; i < TABLE_ENTRIES; i++)
			offer_keepalive(32'h0A00_0100 + i, random_mac(), 32'd20);
		// Table full: dropped, then dropped again with a jump that ages out all sixteen.
		offer_keepalive(32'h0A00_FFFF, random_mac(), 32'd20);
		offer_keepalive(32'h1234_5678, random_mac(), 32'h8000_0000);
		// Time wrap: an entry seen just before the wrap survives a small age after it.
		offer_keepalive(32'h5555_5555, random_mac(), 32'hFFFF_FFF0);
		offer_keepalive(32'hAAAA_AAAA, random_mac(), 32'd5);
		// Touched slot at timeout zero: same second stays, next second goes.
		write_timeout('0);
		offer_keepalive(32'h5555_5555, random_mac(), 32'd6);
		offer_keepalive(32'h0000_0001, random_mac(), 32'd6);
		offer_keepalive(32'h0000_0002, random_mac(), 32'd7);

		// Random phases: a small pool of peers revisited at a pace tied to the
		// timeout, so tables fill, refresh and age out; five words in a hundred are
		// stray addresses and three in a hundred are wild clock jumps.
		phase_timeout[0] = 16'hFFFF;
		phase_timeout[1] = 16'd0;
		phase_timeout[2] = 16'd7;
		phase_timeout[3] = TIMEOUT_RESET;
		phase_timeout[4] = 16'($urandom_range(1, 200));
		phase_timeout[5] = 16'($urandom_range(0, 65535));
		clock_s = 32'd100;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_timeout(phase_timeout[ph]);
			gaps_on = (ph != 2);       // one phase runs with no idling at all
			if (ph == 3)
				clock_s = 32'hFFFF_FF00; // small steps carry this phase across the wrap
			pool_n = $urandom_range(12, 28);
			for (int k = 0; k < pool_n; k++)
				peer_pool[k] = $urandom;
			step_max = phase_timeout[ph] / 10 + 3;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 4 && n == 40)
					hold_req = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 5)
					ip = $urandom;
				else
					ip = peer_pool[$urandom_range(0, pool_n - 1)];
				if (pick >= 5 && pick < 8)
					clock_s = $urandom;
				else
					clock_s = clock_s + $urandom_range(0, step_max);
				offer_keepalive(ip, random_mac(), clock_s);
			end
		end

		// Drain, then a margin for any stray result word.
		gaps_on = 1'b0;
		ka_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== peer_table_with_aging_core.f =====
+incdir+rtl
rtl/pta_pkg.sv
rtl/pta_if.sv
rtl/pta_cell.sv
rtl/peer_table_with_aging_core.sv
verif/peer_table_with_aging_core_tb.sv
